### src/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define MMAR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// condition that must never be seen outside reset
`define MMAR_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

### src/mmar_pkg.sv
package mmar_pkg;

   // fixed field widths
   localparam int SUM_BITS           = 64;
   localparam int REPORT_BITS        = 32;
   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH        = 4;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 64;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OP_MODE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ELEM_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL_ENABLE = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL_VALUE  = 2'd3;

   // reduction modes, modes two and three both average
   localparam logic [1:0] OP_MAX = 2'd0;
   localparam logic [1:0] OP_MIN = 2'd1;
   localparam logic [1:0] OP_AVG = 2'd2;

   typedef enum logic [1:0] {
      EW_INT8  = 2'd0,
      EW_INT16 = 2'd1,
      EW_INT32 = 2'd2,
      EW_INT64 = 2'd3
   } elem_width_type;

   typedef struct packed {
      logic [1:0]                  op_mode;
      elem_width_type              elem_width;
      logic                        fill_enable;
      logic signed [SUM_BITS-1:0]  marker_value;
   } cfg_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] sample;
      logic                       chunk_last;
      logic                       restart;
   } req_payload_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] result;
      logic                       result_valid;
      logic [REPORT_BITS-1:0]     included_count;
      logic                       sum_overflow;
   } rsp_payload_type;

   // classified beat handed from the front to the back
   typedef struct packed {
      logic signed [SUM_BITS-1:0] sample;
      logic                       candidate;
      logic                       chunk_last;
      logic                       restart;
   } queue_entry_type;

   typedef enum logic {
      BACK_RUN = 1'b0,
      BACK_DIV = 1'b1
   } back_state_type;

   // sign extend the low bits selected by the sample width
   function automatic logic signed [SUM_BITS-1:0] narrow_value(
      input logic [SUM_BITS-1:0] v,
      input elem_width_type      ew
   );
      logic signed [SUM_BITS-1:0] r;
      case (ew)
         EW_INT8:  r = {{(SUM_BITS-8){v[7]}}, v[7:0]};
         EW_INT16: r = {{(SUM_BITS-16){v[15]}}, v[15:0]};
         EW_INT32: r = {{(SUM_BITS-32){v[31]}}, v[31:0]};
         default:  r = v;
      endcase
      return r;
   endfunction

endpackage

### src/masked_min_max_avg_reduce_top.sv
// Masked min / max / average reduction over a stream of signed samples.
// Input beats (req_) carry one sample with chunk_last and restart flags; a
// beat is taken when req_valid is high and req_stall is low. A beat with
// chunk_last set produces one result beat (rsp_) holding the running max,
// min or truncated average since the last restart, a valid flag, the
// included count and the sum saturation flag. Other beats give no result.
// The csr_ port writes op_mode, elem_width, fill_enable and marker_value; write
// only while no beat is in flight.
// A max or min result passes through the queue entry and then the result
// register; an average also waits on a 64-step shift-subtract divider that
// runs one quotient bit per cycle. Throughput is one beat per cycle, but a
// chunk end waits while the result register is held by rsp_stall, and an
// averaging chunk end holds the back end through the divide and its pickup.
// A four-entry queue separates classification from the reduction, so input
// keeps flowing while the result register waits on rsp_stall; once the queue
// fills, req_stall rises. Reset (synchronous) empties the queue, clears the
// reduction and restores the register defaults.
module masked_min_max_avg_reduce_top
   import mmar_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   cfg_type                    cfg_ff, cfg_in;
   logic                       queue_full;
   logic                       push;
   queue_entry_type            push_entry;
   logic                       pop;
   logic                       head_valid;
   queue_entry_type            head_entry;
   logic                       div_start;
   logic                       div_negate;
   logic [SUM_BITS-1:0]        div_magnitude;
   logic [COUNT_BITS-1:0]      div_divisor;
   logic                       div_done;
   logic signed [SUM_BITS-1:0] div_quotient;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_OP_MODE:     cfg_in.op_mode      = csr_write_data[1:0];
            CSR_ELEM_WIDTH:  cfg_in.elem_width   = elem_width_type'(csr_write_data[1:0]);
            CSR_FILL_ENABLE: cfg_in.fill_enable  = csr_write_data[0];
            CSR_FILL_VALUE:  cfg_in.marker_value = csr_write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.op_mode      <= OP_MAX;
         cfg_ff.elem_width   <= EW_INT32;
         cfg_ff.fill_enable  <= 1'b0;
         cfg_ff.marker_value <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mmar_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   mmar_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_entry(head_entry)
   );

   mmar_back #(
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head_valid   (head_valid),
      .head_entry   (head_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .div_start    (div_start),
      .div_negate   (div_negate),
      .div_magnitude(div_magnitude),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   mmar_div #(
      .COUNT_BITS(COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .negate   (div_negate),
      .magnitude(div_magnitude),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule

### src/mmar_front.sv
module mmar_front
   import mmar_pkg::*;
(
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   input  cfg_type         cfg,
   input  logic            queue_full,
   output logic            push,
   output queue_entry_type push_entry
);

   logic signed [SUM_BITS-1:0] sample_n;
   logic signed [SUM_BITS-1:0] fill_n;

   // narrow sample and marker at the current width
   always_comb begin
      sample_n = narrow_value(req_payload.sample, cfg.elem_width);
      fill_n   = narrow_value(cfg.marker_value, cfg.elem_width);
   end

   // classify and push into the queue
   always_comb begin
      req_stall             = queue_full;
      push                  = req_valid && !queue_full;
      push_entry.sample     = sample_n;
      push_entry.candidate  = !(cfg.fill_enable && (sample_n == fill_n));
      push_entry.chunk_last = req_payload.chunk_last;
      push_entry.restart    = req_payload.restart;
   end

endmodule

### src/mmar_fifo.sv
module mmar_fifo
   import mmar_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            head_valid,
   output queue_entry_type head_entry
);

`include "assert_macros.svh"

   localparam int PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (fill_ff == FILL_BITS'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   `MMAR_NEVER(a_pop_empty, clock, reset, pop && (fill_ff == '0), "pop from empty queue")

endmodule

### src/mmar_div.sv
module mmar_div
   import mmar_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       negate,
   input  logic [SUM_BITS-1:0]        magnitude,
   input  logic [COUNT_BITS-1:0]      divisor,
   output logic                       done,
   output logic signed [SUM_BITS-1:0] quotient
);

   localparam int STEP_BITS = $clog2(SUM_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [SUM_BITS-1:0]   quo_ff, quo_in;
   logic [COUNT_BITS-1:0] divisor_ff, divisor_in;
   logic                  negate_ff, negate_in;
   logic [COUNT_BITS:0]   rem_shift;
   logic [COUNT_BITS:0]   rem_diff;
   logic                  fits;

   // one restoring step per cycle, quotient bits shift in from the right
   always_comb begin
      rem_shift  = {rem_ff, quo_ff[SUM_BITS-1]};
      rem_diff   = rem_shift - {1'b0, divisor_ff};
      fits       = (rem_shift >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      negate_in  = negate_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         quo_in     = magnitude;
         divisor_in = divisor;
         negate_in  = negate;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
         quo_in  = {quo_ff[SUM_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      negate_ff  <= negate_in;
   end

   assign done     = done_ff;
   assign quotient = negate_ff ? -quo_ff : quo_ff;

endmodule

### src/mmar_back.sv
module mmar_back
   import mmar_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       head_valid,
   input  queue_entry_type            head_entry,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,
   output logic                       div_start,
   output logic                       div_negate,
   output logic [SUM_BITS-1:0]        div_magnitude,
   output logic [COUNT_BITS-1:0]      div_divisor,
   input  logic                       div_done,
   input  logic signed [SUM_BITS-1:0] div_quotient
);

`include "assert_macros.svh"

   localparam int WIDE_BITS = (COUNT_BITS > REPORT_BITS) ? COUNT_BITS : REPORT_BITS;
   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   back_state_type             state_ff, state_in;
   logic signed [SUM_BITS-1:0] best_ff, best_in;
   logic                       seen_ff, seen_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [COUNT_BITS-1:0]      total_ff, total_in;
   logic                       ovf_ff, ovf_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_payload_ff, rsp_payload_in;

   logic signed [SUM_BITS-1:0] eff_best, eff_sum, new_best, new_sum;
   logic                       eff_seen, eff_ovf, new_seen, new_ovf;
   logic [COUNT_BITS-1:0]      eff_total, new_total, report_total;
   logic [WIDE_BITS-1:0]       total_wide;
   logic [REPORT_BITS-1:0]     count_report;
   logic signed [SUM_BITS:0]   sum_wide;
   logic signed [SUM_BITS-1:0] s;
   logic                       include_it;
   logic                       avg_mode;
   logic                       out_free;
   logic                       load_out;

   // state after an optional restart, then after this sample
   always_comb begin
      s         = head_entry.sample;
      avg_mode  = cfg.op_mode[1];
      eff_best  = head_entry.restart ? '0 : best_ff;
      eff_seen  = head_entry.restart ? 1'b0 : seen_ff;
      eff_sum   = head_entry.restart ? '0 : sum_ff;
      eff_total = head_entry.restart ? '0 : total_ff;
      eff_ovf   = head_entry.restart ? 1'b0 : ovf_ff;

      include_it = head_entry.candidate && (eff_total != '1);
      sum_wide   = {eff_sum[SUM_BITS-1], eff_sum} + {s[SUM_BITS-1], s};

      new_best  = eff_best;
      new_seen  = eff_seen;
      new_sum   = eff_sum;
      new_total = eff_total;
      new_ovf   = eff_ovf;
      if (include_it) begin
         if (!eff_seen) begin
            new_best = s;
         end else if ((cfg.op_mode == OP_MAX) && (s > eff_best)) begin
            new_best = s;
         end else if ((cfg.op_mode == OP_MIN) && (s < eff_best)) begin
            new_best = s;
         end
         new_seen  = 1'b1;
         new_total = eff_total + 1'b1;
         if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
            new_sum = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
            new_ovf = 1'b1;
         end else begin
            new_sum = sum_wide[SUM_BITS-1:0];
         end
      end
   end

   // included count clamped to the report width
   always_comb begin
      report_total = (state_ff == BACK_DIV) ? total_ff : new_total;
      total_wide   = WIDE_BITS'(report_total);
      count_report = (total_wide > WIDE_BITS'({REPORT_BITS{1'b1}})) ?
                     '1 : total_wide[REPORT_BITS-1:0];
   end

   // sequencer: take beats, start the divide at an averaging chunk end
   always_comb begin
      out_free       = !rsp_valid_ff || !rsp_stall;
      state_in       = state_ff;
      pop            = 1'b0;
      div_start      = 1'b0;
      load_out       = 1'b0;
      rsp_payload_in = rsp_payload_ff;
      case (state_ff)
         BACK_RUN: begin
            pop = head_valid && (!head_entry.chunk_last || out_free);
            if (pop && head_entry.chunk_last) begin
               if (avg_mode && new_seen) begin
                  div_start = 1'b1;
                  state_in  = BACK_DIV;
               end else begin
                  load_out                      = 1'b1;
                  rsp_payload_in.result         = new_seen ?
                                                  narrow_value(new_best, cfg.elem_width) : '0;
                  rsp_payload_in.result_valid   = new_seen;
                  rsp_payload_in.included_count = count_report;
                  rsp_payload_in.sum_overflow   = new_ovf;
               end
            end
         end
         BACK_DIV: begin
            if (div_done) begin
               load_out                      = 1'b1;
               rsp_payload_in.result         = narrow_value(div_quotient, cfg.elem_width);
               rsp_payload_in.result_valid   = 1'b1;
               rsp_payload_in.included_count = count_report;
               rsp_payload_in.sum_overflow   = ovf_ff;
               state_in                      = BACK_RUN;
            end
         end
         default: begin
            state_in = BACK_RUN;
         end
      endcase
   end

   assign div_negate    = new_sum[SUM_BITS-1];
   assign div_magnitude = new_sum[SUM_BITS-1] ? -new_sum : new_sum;
   assign div_divisor   = new_total;

   // reduction state
   always_comb begin
      best_in  = pop ? new_best : best_ff;
      seen_in  = pop ? new_seen : seen_ff;
      sum_in   = pop ? new_sum : sum_ff;
      total_in = pop ? new_total : total_ff;
      ovf_in   = pop ? new_ovf : ovf_ff;
   end

   // result register
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_RUN;
         best_ff      <= '0;
         seen_ff      <= 1'b0;
         sum_ff       <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         best_ff      <= best_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `MMAR_ASSERT(a_hold_in_div, clock, reset, (state_ff == BACK_DIV) |-> !pop, "beat taken during divide")
   `MMAR_ASSERT(a_div_done_slot, clock, reset, div_done |-> ((state_ff == BACK_DIV) && !rsp_valid_ff), "divide finished with result slot busy")
   `MMAR_ASSERT(a_ovf_sticky, clock, reset, (ovf_ff && !(pop && head_entry.restart)) |=> ovf_ff, "overflow flag dropped without restart")

endmodule
